[sv/pba_pkg.sv]
// Shared constants, request and response beat types for the block allocator.
// No dependencies; the other files refer to this package by scoped names or import it.
package pba_pkg;

    localparam int POOL_PAGES     = 16;
    localparam int PAGE_BYTES     = 4096;
    localparam int SMALLEST_BLOCK = 32;
    localparam int CLASS_COUNT    = 8;

    localparam int OFFSET_W = 16;
    localparam int SIZE_W   = 16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFSET_W-1:0] block_offset;
    } t_req;

    typedef struct packed {
        logic                granted;
        logic [OFFSET_W-1:0] granted_offset;
    } t_resp;

endpackage

[sv/power_of_two_block_allocator.sv]
// Power-of-two block allocator: results cannot be held off. An allocate from a nonempty
// class list passes S_ALLOC and S_POP, and a new beat can be taken in its result cycle.
// An allocate that opens a new page answers from S_ALLOC, then stays busy in S_CARVE to
// link each remaining block of the page, since the link memory takes one write a cycle.
// A free (no result) or a failing allocate returns to idle from S_FREE or S_ALLOC.
// Reset is synchronous and active low; the block is ready as soon as reset releases.
module power_of_two_block_allocator #(
    parameter int POOL_PAGES     = pba_pkg::POOL_PAGES,
    parameter int PAGE_BYTES     = pba_pkg::PAGE_BYTES,
    parameter int SMALLEST_BLOCK = pba_pkg::SMALLEST_BLOCK,
    parameter int CLASS_COUNT    = pba_pkg::CLASS_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pba_pkg::t_req  i_req,
    output logic          o_done,
    output pba_pkg::t_resp o_resp
);

    localparam int SB_SH   = $clog2(SMALLEST_BLOCK);
    localparam int PG_SH   = $clog2(PAGE_BYTES);
    localparam int UPP_SH  = PG_SH - SB_SH;
    localparam int UPP     = PAGE_BYTES / SMALLEST_BLOCK;
    localparam int TOTAL   = POOL_PAGES * UPP;
    localparam int UNIT_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int PG_W    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int PL_W    = $clog2(POOL_PAGES + 1);
    localparam int CNT_W   = UPP_SH + 1;
    localparam int BIGGEST = SMALLEST_BLOCK << (CLASS_COUNT - 1);
    localparam int LARGEST = (BIGGEST > PAGE_BYTES) ? PAGE_BYTES : BIGGEST;
    localparam int OFF_W   = pba_pkg::OFFSET_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_CARVE = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic              r_bad, n_bad;
    logic [UNIT_W-1:0] r_unit, n_unit;
    logic              r_pg_ok, n_pg_ok;
    logic [PL_W-1:0]   r_pages_left, n_pages_left;
    logic [UNIT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_done, n_done;
    pba_pkg::t_resp    r_resp, n_resp;

    logic              r_hv [CLASS_COUNT];
    logic [UNIT_W-1:0] r_hu [CLASS_COUNT];

    logic [UNIT_W:0]   m_link [TOTAL];
    logic [UNIT_W:0]   r_link_rd;
    logic [CLS_W-1:0]  m_page [POOL_PAGES];
    logic [CLS_W-1:0]  r_page_rd;

    logic              link_we;
    logic [UNIT_W-1:0] link_wa, link_ra;
    logic [UNIT_W:0]   link_wd;
    logic              page_we;
    logic [PG_W-1:0]   page_wa, page_ra;
    logic [CLS_W-1:0]  page_wd;
    logic              head_we;
    logic [CLS_W-1:0]  head_wa;
    logic              head_wv;
    logic [UNIT_W-1:0] head_wu;

    logic [CLS_W-1:0]  cls_calc;
    logic              size_bad;
    logic [31:0]       in_page;
    logic [PL_W-1:0]   pl_dec;
    logic [UNIT_W-1:0] step, base, free_step, free_unit;
    logic [CNT_W-1:0]  count;
    logic [CLS_W-1:0]  free_cls;

    always_comb begin
        cls_calc = CLS_W'(CLASS_COUNT - 1);
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if ((32'(SMALLEST_BLOCK) << c) >= 32'(i_req.request_size)) begin
                cls_calc = CLS_W'(c);
            end
        end
    end

    assign size_bad  = (i_req.request_size == '0) || (32'(i_req.request_size) > 32'(LARGEST));
    assign in_page   = 32'(i_req.block_offset) >> PG_SH;
    assign pl_dec    = r_pages_left - PL_W'(1);
    assign step      = UNIT_W'(1) << r_cls;
    assign count     = CNT_W'(UPP) >> r_cls;
    assign base      = UNIT_W'(32'(pl_dec) << UPP_SH);
    assign free_cls  = r_page_rd;
    assign free_step = UNIT_W'(1) << free_cls;
    assign free_unit = r_unit & ~(free_step - UNIT_W'(1));
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_cls        = r_cls;
        n_bad        = r_bad;
        n_unit       = r_unit;
        n_pg_ok      = r_pg_ok;
        n_pages_left = r_pages_left;
        n_addr       = r_addr;
        n_left       = r_left;
        n_done       = 1'b0;
        n_resp       = r_resp;
        link_we      = 1'b0;
        link_wa      = r_addr;
        link_wd      = '0;
        link_ra      = r_hu[r_cls];
        page_we      = 1'b0;
        page_wa      = pl_dec[PG_W-1:0];
        page_wd      = r_cls;
        page_ra      = in_page[PG_W-1:0];
        head_we      = 1'b0;
        head_wa      = r_cls;
        head_wv      = 1'b0;
        head_wu      = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cls   = cls_calc;
                    n_bad   = size_bad;
                    n_unit  = UNIT_W'(32'(i_req.block_offset) >> SB_SH);
                    n_pg_ok = (in_page < 32'(POOL_PAGES)) && (in_page >= 32'(r_pages_left));
                    n_state = (i_req.func == pba_pkg::FUNC_FREE) ? S_FREE : S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (r_bad) begin
                    n_done  = 1'b1;
                    n_resp  = '0;
                    n_state = S_IDLE;
                end else if (r_hv[r_cls]) begin
                    n_unit  = r_hu[r_cls];
                    n_state = S_POP;
                end else if (r_pages_left == '0) begin
                    n_done  = 1'b1;
                    n_resp  = '0;
                    n_state = S_IDLE;
                end else begin
                    page_we      = 1'b1;
                    n_pages_left = pl_dec;
                    head_we      = 1'b1;
                    head_wv      = (count > CNT_W'(1));
                    head_wu      = base + step;
                    n_done       = 1'b1;
                    n_resp.granted        = 1'b1;
                    n_resp.granted_offset = OFF_W'(32'(base) << SB_SH);
                    n_addr       = base + step;
                    n_left       = count - CNT_W'(1);
                    n_state      = (count > CNT_W'(1)) ? S_CARVE : S_IDLE;
                end
            end
            S_POP: begin
                head_we = 1'b1;
                head_wv = r_link_rd[UNIT_W];
                head_wu = r_link_rd[UNIT_W-1:0];
                n_done  = 1'b1;
                n_resp.granted        = 1'b1;
                n_resp.granted_offset = OFF_W'(32'(r_unit) << SB_SH);
                n_state = S_IDLE;
            end
            S_FREE: begin
                if (r_pg_ok) begin
                    link_we = 1'b1;
                    link_wa = free_unit;
                    link_wd = {r_hv[free_cls], r_hu[free_cls]};
                    head_we = 1'b1;
                    head_wa = free_cls;
                    head_wv = 1'b1;
                    head_wu = free_unit;
                end
                n_state = S_IDLE;
            end
            S_CARVE: begin
                link_we = 1'b1;
                link_wa = r_addr;
                link_wd = (r_left == CNT_W'(1)) ? '0 : {1'b1, r_addr + step};
                n_addr  = r_addr + step;
                n_left  = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pages_left <= PL_W'(POOL_PAGES);
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pages_left <= n_pages_left;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_bad   <= n_bad;
        r_unit  <= n_unit;
        r_pg_ok <= n_pg_ok;
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_resp  <= n_resp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_hv[c] <= 1'b0;
            end
        end else if (head_we) begin
            r_hv[head_wa] <= head_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_hu[head_wa] <= head_wu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            m_link[link_wa] <= link_wd;
        end
        r_link_rd <= m_link[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (page_we) begin
            m_page[page_wa] <= page_wd;
        end
        r_page_rd <= m_page[page_ra];
    end

    assign o_done = r_done;
    assign o_resp = r_resp;

endmodule

[sv/pba_checker.sv]
// Port-level checks for the block allocator and the bind that attaches them.
// Depends on pba_pkg and on the top level power_of_two_block_allocator.
module pba_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input pba_pkg::t_req  i_req,
    input logic           o_done,
    input pba_pkg::t_resp o_resp
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Block did not go busy after accepting a beat.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_resp.granted) |-> (o_resp.granted_offset == '0))
        else $error("Refused allocation carries a nonzero offset.");

    a_free_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.func == pba_pkg::FUNC_FREE) |=> !o_done ##1 !o_done)
        else $error("A free produced a result beat.");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("Result beat appeared without preceding work.");

endmodule

bind power_of_two_block_allocator pba_checker u_pba_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_req  (i_req),
    .o_done (o_done),
    .o_resp (o_resp)
);

[bench/power_of_two_block_allocator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for power_of_two_block_allocator, with a clocked driver and monitor
// and an in-bench predictor of the class free lists. Depends on pba_pkg and the block only.
module power_of_two_block_allocator_test;

    import pba_pkg::*;

    localparam int UNITS_PER_PAGE = PAGE_BYTES / SMALLEST_BLOCK;
    localparam int TOTAL_UNITS    = POOL_PAGES * UNITS_PER_PAGE;
    localparam int LARGEST_BLOCK  = ((SMALLEST_BLOCK << (CLASS_COUNT - 1)) > PAGE_BYTES) ?
                                    PAGE_BYTES : (SMALLEST_BLOCK << (CLASS_COUNT - 1));
    localparam int RANDOM_ITEMS   = 1280;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int IDLE_PLAN [4]  = '{0, 56, 20, 0};

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_resp o_resp;

    t_req  request_q [$];
    t_resp grant_q [$];
    int    held_q [$];
    int    returned_q [$];
    int    idle_pct;
    int    mismatch_count = 0;
    int    cycle_count = 0;

    bit    head_ok [CLASS_COUNT];
    int    head_unit [CLASS_COUNT];
    bit    link_ok [TOTAL_UNITS];
    int    link_unit [TOTAL_UNITS];
    int    page_tag [POOL_PAGES];
    int    pages_free = POOL_PAGES;

    power_of_two_block_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_resp  (o_resp)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic carve_page(input int page, input int cls);
        int step;
        int cnt;
        int base;
        step = 1 << cls;
        cnt  = UNITS_PER_PAGE / step;
        base = page * UNITS_PER_PAGE;
        page_tag[page] = cls + 1;
        for (int i = 0; i + 1 < cnt; i++) begin
            link_ok[base + i * step]   = 1'b1;
            link_unit[base + i * step] = base + (i + 1) * step;
        end
        link_ok[base + (cnt - 1) * step]   = head_ok[cls];
        link_unit[base + (cnt - 1) * step] = head_unit[cls];
        head_ok[cls]   = 1'b1;
        head_unit[cls] = base;
    endtask

    task automatic predict_grant(input t_req r);
        int    cls;
        int    unit;
        int    page;
        int    step;
        int    rel;
        t_resp res;
        res = '0;
        if (r.func == FUNC_ALLOC) begin
            if (r.request_size != 0 && int'(r.request_size) <= LARGEST_BLOCK) begin
                cls = 0;
                while (cls + 1 < CLASS_COUNT && (SMALLEST_BLOCK << cls) < int'(r.request_size))
                    cls++;
                if (!head_ok[cls] && pages_free > 0) begin
                    pages_free--;
                    carve_page(pages_free, cls);
                end
                if (head_ok[cls]) begin
                    unit           = head_unit[cls];
                    head_ok[cls]   = link_ok[unit];
                    head_unit[cls] = link_unit[unit];
                    res.granted        = 1'b1;
                    res.granted_offset = OFFSET_W'(unit * SMALLEST_BLOCK);
                end
            end
            grant_q.push_back(res);
        end else begin
            page = int'(r.block_offset) / PAGE_BYTES;
            if (page < POOL_PAGES && page_tag[page] != 0) begin
                cls  = page_tag[page] - 1;
                step = 1 << cls;
                rel  = (int'(r.block_offset) % PAGE_BYTES) / SMALLEST_BLOCK;
                unit = page * UNITS_PER_PAGE + (rel / step) * step;
                link_ok[unit]   = head_ok[cls];
                link_unit[unit] = head_unit[cls];
                head_ok[cls]    = 1'b1;
                head_unit[cls]  = unit;
            end
        end
    endtask

    task automatic queue_alloc(input int size);
        t_req r;
        r = '0;
        r.func         = FUNC_ALLOC;
        r.request_size = SIZE_W'(size);
        r.block_offset = OFFSET_W'($urandom);
        request_q.push_back(r);
    endtask

    task automatic queue_free(input int offset);
        t_req r;
        r = '0;
        r.func         = FUNC_FREE;
        r.request_size = SIZE_W'($urandom);
        r.block_offset = OFFSET_W'(offset);
        request_q.push_back(r);
        returned_q.push_back(offset);
        if (returned_q.size() > 16)
            void'(returned_q.pop_front());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                predict_grant(i_req);
            if (!(start && busy)) begin
                if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_req <= request_q.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected result beat", int'(o_resp), 0);
            end else begin
                want = grant_q.pop_front();
                if (o_resp.granted !== want.granted)
                    report_mismatch("granted", int'(o_resp.granted), int'(want.granted));
                if (o_resp.granted_offset !== want.granted_offset)
                    report_mismatch("granted_offset", int'(o_resp.granted_offset),
                                    int'(want.granted_offset));
                if (want.granted)
                    held_q.push_back(int'(want.granted_offset));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL power_of_two_block_allocator");
            $finish;
        end
    end

    initial begin
        int pick;
        int cls;
        int hi;
        int lo;
        int idx;
        int off;
        idle_pct       = 30;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_alloc(0);
        queue_free('h0000);
        queue_alloc(1);
        queue_alloc(32);
        queue_alloc(33);
        queue_alloc(4096);
        queue_alloc(4097);
        queue_alloc(65535);
        queue_alloc(100);
        queue_alloc(200);
        queue_alloc(500);
        queue_alloc(1000);
        queue_alloc(2000);
        queue_free('hF025);
        queue_alloc(20);
        queue_free('hF000);
        queue_free('hF000);
        queue_alloc(32);
        queue_alloc(32);
        queue_free('hD000);
        queue_alloc(4000);
        queue_free('hFFFF);
        queue_alloc(1);
        queue_free('h1234);

        while (request_q.size() != 0 || grant_q.size() != 0) @(posedge i_clk);
        held_q.delete();
        returned_q.delete();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = IDLE_PLAN[n * 4 / RANDOM_ITEMS];
            while (request_q.size() > 3) @(posedge i_clk);
            pick = $urandom_range(99);
            if (pick < 50) begin
                if (pick < 3) begin
                    queue_alloc(0);
                end else if (pick < 7) begin
                    queue_alloc($urandom_range(65535, LARGEST_BLOCK + 1));
                end else begin
                    cls = $urandom_range(CLASS_COUNT - 1);
                    hi  = SMALLEST_BLOCK << cls;
                    lo  = (cls == 0) ? 1 : hi / 2 + 1;
                    queue_alloc($urandom_range(hi, lo));
                end
            end else if (pick < 88 && held_q.size() > 0) begin
                idx = $urandom_range(held_q.size() - 1);
                off = held_q[idx];
                held_q.delete(idx);
                if (pick[0])
                    off += $urandom_range(SMALLEST_BLOCK - 1);
                queue_free(off);
            end else if (pick < 94 && returned_q.size() > 0) begin
                queue_free(returned_q[$urandom_range(returned_q.size() - 1)]);
            end else begin
                queue_free($urandom_range(65535));
            end
        end

        while (request_q.size() != 0 || start || grant_q.size() != 0 || busy)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS power_of_two_block_allocator");
        end else begin
            $display("FAIL power_of_two_block_allocator");
        end
        $finish;
    end

endmodule
